// ----- rtl/pooled_linked_queue_manager_unit_defines.svh -----
// Assertion macros for the pooled linked queue manager.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef POOLED_LINKED_QUEUE_MANAGER_UNIT_DEFINES_SVH
`define POOLED_LINKED_QUEUE_MANAGER_UNIT_DEFINES_SVH
// Property holds at every edge outside reset.
`define PLQM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked also during reset.
`define PLQM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- rtl/plqm_pkg.sv -----
// Package for the pooled linked queue manager: widths, command codes, payload types.
// No dependencies.
package plqm_pkg;
  localparam int unsigned DefEntries = 32;
  localparam int unsigned DefQueues  = 8;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned QidW   = 3;
  localparam int unsigned EntryW = 5;

  localparam logic [CmdW-1:0] CMD_ALLOC  = 3'd0;
  localparam logic [CmdW-1:0] CMD_FREE   = 3'd1;
  localparam logic [CmdW-1:0] CMD_INSERT = 3'd2;
  localparam logic [CmdW-1:0] CMD_RMHEAD = 3'd3;
  localparam logic [CmdW-1:0] CMD_RMENT  = 3'd4;
  localparam logic [CmdW-1:0] CMD_PEEK   = 3'd5;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [QidW-1:0]   queue_id;
    logic [EntryW-1:0] entry_index;
  } plqm_in_t;

  typedef struct packed {
    logic [EntryW-1:0] result_entry;
    logic              result_valid;
    logic              queue_empty;
    logic              free_empty;
  } plqm_out_t;
endpackage

// ----- rtl/pooled_linked_queue_manager_unit.sv -----
// Pooled linked queue manager: sequencer over one next/prev link memory pair.
// Depends on plqm_pkg and pooled_linked_queue_manager_unit_defines.svh.
// Commands that change nothing go straight to the done state; the others read
// the tail's link and then the head's. A peek ends there; an alloc or remove head
// then unlinks the head, and a free or insert links in the new entry. Remove entry
// then walks the queue one link memory read per cycle, up to ENTRIES links past
// the head, and unlinks the entry it finds. After reset a clearing pass writes the
// initial links of all ENTRIES entries with busy high. The receiver cannot stall:
// each result is on result when done is high for a single cycle, as busy falls.
`include "pooled_linked_queue_manager_unit_defines.svh"
module pooled_linked_queue_manager_unit #(
  parameter int unsigned ENTRIES = plqm_pkg::DefEntries,
  parameter int unsigned QUEUES  = plqm_pkg::DefQueues
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  plqm_pkg::plqm_in_t cmd,
  output logic               busy,
  output logic               done,
  output plqm_pkg::plqm_out_t result
);
  import plqm_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned SW = $clog2(ENTRIES + 1);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_WR1   = 4'd4;
  localparam logic [3:0] S_WR2   = 4'd5;
  localparam logic [3:0] S_WALK  = 4'd6;
  localparam logic [3:0] S_UNL   = 4'd7;
  localparam logic [3:0] S_UNL2  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [AW-1:0] next_mem [ENTRIES];
  logic [AW-1:0] prev_mem [ENTRIES];
  logic [AW-1:0] next_rd, prev_rd;
  logic [AW-1:0] rd_addr;
  logic          nwe, pwe;
  logic [AW-1:0] nwa, nwd, pwa, pwd;

  logic [AW-1:0] qtail [QUEUES];
  logic [QUEUES-1:0] qne;
  logic [AW-1:0] ftail;
  logic          fne;

  logic [3:0]    state;
  logic [CmdW-1:0] op;
  logic [QW-1:0] q;
  logic [AW-1:0] e;
  logic [AW-1:0] tl, hd;
  logic          ne, valid;
  logic [AW-1:0] got;
  logic [SW-1:0] steps;
  logic [AW-1:0] init_cnt;

  always_ff @(posedge clk) begin
    if (nwe) next_mem[nwa] <= nwd;
    if (pwe) prev_mem[pwa] <= pwd;
    next_rd <= next_mem[rd_addr];
    prev_rd <= prev_mem[rd_addr];
  end

  logic qok, eok, ins, uses_q;
  assign uses_q = (cmd.command == CMD_INSERT) || (cmd.command == CMD_RMHEAD) ||
                  (cmd.command == CMD_RMENT) || (cmd.command == CMD_PEEK);
  assign qok = ({{(32-QidW){1'b0}}, cmd.queue_id} < QUEUES);
  assign eok = ({{(32-EntryW){1'b0}}, cmd.entry_index} < ENTRIES);
  assign ins = (op == CMD_FREE) || (op == CMD_INSERT);

  always_comb begin
    rd_addr = tl;
    nwe = 1'b0; pwe = 1'b0;
    nwa = init_cnt; nwd = init_cnt + AW'(1);
    pwa = init_cnt; pwd = init_cnt - AW'(1);
    case (state)
      S_INIT: begin
        nwe = 1'b1; pwe = 1'b1;
        if (init_cnt == AW'(ENTRIES - 1)) nwd = '0;
        if (init_cnt == '0) pwd = AW'(ENTRIES - 1);
      end
      S_RD2: rd_addr = next_rd;
      S_WALK: rd_addr = next_rd;
      S_UNL: rd_addr = e;
      S_WR1: begin
        if (ins) begin
          nwe = 1'b1; pwe = 1'b1; nwa = e; pwa = e;
          nwd = ne ? hd : e;
          pwd = ne ? tl : e;
        end else begin
          pwe = 1'b1; pwa = next_rd; pwd = tl;
          nwe = 1'b1; nwa = tl; nwd = next_rd;
        end
      end
      S_WR2: begin
        if (ins) begin
          pwe = 1'b1; pwa = hd; pwd = e;
          nwe = 1'b1; nwa = tl; nwd = e;
        end
      end
      S_UNL2: begin
        nwe = 1'b1; nwa = prev_rd; nwd = next_rd;
        pwe = 1'b1; pwa = next_rd; pwd = prev_rd;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_cnt <= '0;
      qne <= '0;
      fne <= 1'b1;
      ftail <= AW'(ENTRIES - 1);
      done <= 1'b0;
      for (int i = 0; i < QUEUES; i++) qtail[i] <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + AW'(1);
          if (init_cnt == AW'(ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op <= cmd.command;
            q <= QW'(cmd.queue_id);
            e <= AW'(cmd.entry_index);
            valid <= 1'b0;
            got <= '0;
            state <= S_DONE;
            if (cmd.command == CMD_ALLOC) begin
              tl <= ftail; ne <= fne;
              if (fne) state <= S_RD1;
            end else if (cmd.command == CMD_FREE) begin
              tl <= ftail; ne <= fne;
              if (eok) state <= S_RD1;
            end else if (uses_q && qok) begin
              tl <= qtail[QW'(cmd.queue_id)];
              ne <= qne[QW'(cmd.queue_id)];
              if (cmd.command == CMD_INSERT) begin
                if (eok) state <= S_RD1;
              end else if (cmd.command == CMD_RMENT) begin
                if (eok && qne[QW'(cmd.queue_id)]) state <= S_RD1;
              end else if (qne[QW'(cmd.queue_id)]) begin
                state <= S_RD1;
              end
            end
          end
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          hd <= next_rd;
          steps <= SW'(1);
          state <= S_WR1;
          if (ins) begin
            if (!ne) state <= S_WR1;
          end else if (op == CMD_PEEK) begin
            valid <= 1'b1; got <= next_rd; state <= S_DONE;
          end else if (op == CMD_RMENT) begin
            if (tl == e) begin
              valid <= 1'b1; got <= e;
              if (next_rd == e) begin
                qne[q] <= 1'b0; state <= S_DONE;
              end else begin
                state <= S_UNL;
              end
            end else if (next_rd == tl) begin
              state <= S_DONE;
            end else if (next_rd == e) begin
              valid <= 1'b1; got <= e; state <= S_UNL;
            end else begin
              state <= S_WALK;
            end
          end else begin
            valid <= 1'b1; got <= next_rd;
            if (next_rd == tl) begin
              if (op == CMD_ALLOC) fne <= 1'b0; else qne[q] <= 1'b0;
              state <= S_DONE;
            end
          end
        end
        S_WR1: state <= (ins && ne) ? S_WR2 : S_DONE;
        S_WR2: begin
          hd <= hd;
          state <= S_DONE;
          if (ins) begin
            if (op == CMD_FREE) begin ftail <= e; fne <= 1'b1; end
            else begin qtail[q] <= e; qne[q] <= 1'b1; end
          end
        end
        S_WALK: begin
          if (next_rd == tl || steps == SW'(ENTRIES)) begin
            state <= S_DONE;
          end else if (next_rd == e) begin
            valid <= 1'b1; got <= e; state <= S_UNL;
          end else begin
            steps <= steps + SW'(1);
          end
        end
        S_UNL: state <= S_UNL2;
        S_UNL2: begin
          if (tl == e) qtail[q] <= prev_rd;
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_WR1 && ins && !ne) begin
        if (op == CMD_FREE) begin ftail <= e; fne <= 1'b1; end
        else begin qtail[q] <= e; qne[q] <= 1'b1; end
      end
    end
  end

  logic in_qok;
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) in_qok <= qok;
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      result.result_entry <= EntryW'(valid ? got : '0);
      result.result_valid <= valid;
      result.queue_empty  <= !(in_qok && qne[q]);
      result.free_empty   <= !fne;
    end
  end

  `PLQM_ASSERT(a_done_pulse, clk, rst, done |=> !done, "done lasted more than one cycle")
  `PLQM_ASSERT(a_no_start_busy, clk, rst, done |-> busy == 1'b0, "done while busy")
  `PLQM_ASSERT(a_valid_entry, clk, rst,
    (done && !result.result_valid) |-> result.result_entry == '0, "invalid result not zero")
  `PLQM_ASSERT_ALWAYS(a_reset_init, clk, rst |=> state == S_INIT, "no init after reset")
endmodule
